// ----- src/bppc_pkg.sv -----
// ----------------------------------------------------------------------------
// bppc_pkg
// Shared widths, register indexes, control structs and a saturation helper
// for the barycentric point pin constraint unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bppc_pkg;

  localparam int PosW     = 32;
  localparam int WgtW     = 15;
  localparam int ImW      = 16;
  localparam int AccW     = 49;
  localparam int PntW     = 35;
  localparam int DiffW    = 36;
  localparam int MwW      = 31;
  localparam int SW       = 48;
  localparam int ProdW    = 67;
  localparam int NumW     = 81;
  localparam int QW       = 51;
  localparam int NpW      = 54;
  localparam int ForceW   = 40;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;
  localparam int StepW    = 6;

  localparam logic [StepW-1:0] DivLast = StepW'(QW - 1);
  localparam logic [1:0]       LastIdx = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_A = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_B = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_C = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_X = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_Z = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_INV_MASS = 3'd6;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CALC1 = 7'b0000010,
    ST_CALC2 = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_FIX   = 7'b0100000,
    ST_WAIT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic       in_ready;
    logic       out_valid;
    logic       load_in;
    logic       calc1;
    logic       calc2;
    logic       mul;
    logic       div_step;
    logic       fix;
    logic       load_out;
    logic [1:0] k;
    logic [1:0] a;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_ready;
  } stat_t;

  function automatic logic signed [PosW-1:0] sat32(input logic signed [NpW-1:0] v);
    logic signed [NpW-1:0] hi;
    logic signed [NpW-1:0] lo;
    hi = NpW'(64'sh7FFF_FFFF);
    lo = -NpW'(64'sh8000_0000);
    if (v > hi) begin
      sat32 = hi[PosW-1:0];
    end else if (v < lo) begin
      sat32 = lo[PosW-1:0];
    end else begin
      sat32 = v[PosW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/bppc_ifs.sv -----
// ----------------------------------------------------------------------------
// bppc channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bppc_in_if;
  logic               valid;
  logic               ready;
  logic               clear_force;
  logic signed [31:0] a_x, a_y, a_z;
  logic signed [31:0] b_x, b_y, b_z;
  logic signed [31:0] c_x, c_y, c_z;
  modport source (output valid, clear_force, a_x, a_y, a_z, b_x, b_y, b_z,
                  c_x, c_y, c_z, input ready);
  modport sink   (input valid, clear_force, a_x, a_y, a_z, b_x, b_y, b_z,
                  c_x, c_y, c_z, output ready);
endinterface

interface bppc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_a_x, new_a_y, new_a_z;
  logic signed [31:0] new_b_x, new_b_y, new_b_z;
  logic signed [31:0] new_c_x, new_c_y, new_c_z;
  logic signed [31:0] force_x, force_y, force_z;
  modport source (output valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y,
                  new_b_z, new_c_x, new_c_y, new_c_z, force_x, force_y,
                  force_z, input ready);
  modport sink   (input valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y,
                  new_b_z, new_c_x, new_c_y, new_c_z, force_x, force_y,
                  force_z, output ready);
endinterface

interface bppc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/bppc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bppc_ctrl
// Sequencer: point and sum setup, then multiply / divide / correct for each
// of the nine vertex-axis pairs, then hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bppc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bppc_pkg::stat_t stat,
  output bppc_pkg::cmd_t       cmd
);
  import bppc_pkg::*;

  state_t           state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [1:0]       a_r, a_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    k_nxt        = k_r;
    a_nxt        = a_r;
    cmd          = '0;
    cmd.k        = k_r;
    cmd.a        = a_r;
    cmd.out_valid = out_valid_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CALC1;
        end
      end
      ST_CALC1: begin
        cmd.calc1 = 1'b1;
        state_nxt = ST_CALC2;
      end
      ST_CALC2: begin
        cmd.calc2 = 1'b1;
        k_nxt     = '0;
        a_nxt     = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DivLast) begin
          state_nxt = ST_FIX;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_MUL;
        if (a_r == LastIdx) begin
          a_nxt = '0;
          if (k_r == LastIdx) begin
            state_nxt = ST_WAIT;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          a_nxt = a_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (!out_valid_r || stat.out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (stat.out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      k_r         <= '0;
      a_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      k_r         <= k_nxt;
      a_r         <= a_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> step_r <= DivLast)
    else $error("divider step count out of range");

  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= LastIdx && a_r <= LastIdx)
    else $error("pair index out of range");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result not presented after load");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> state_r == ST_CALC1)
    else $error("accepted item did not start");

endmodule

`default_nettype wire

// ----- src/bppc_dp.sv -----
// ----------------------------------------------------------------------------
// bppc_dp
// Datapath: configuration registers, barycentric point, offset, mass sum,
// force accumulator, shared multiplier, radix-2 divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bppc_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bppc_pkg::cmd_t cmd,
  output bppc_pkg::stat_t     stat,
  bppc_in_if.sink             in_ch,
  bppc_out_if.source          out_ch,
  bppc_cfg_if.sink            cfg_ch
);
  import bppc_pkg::*;

  logic        [WgtW-1:0]     w_r   [3];
  logic signed [PosW-1:0]     tgt_r [3];
  logic        [3*ImW-1:0]    im_r;

  logic signed [PosW-1:0]     pos_r  [3][3];
  logic signed [PosW-1:0]     newp_r [3][3];
  logic signed [PosW-1:0]     opos_r [3][3];
  logic signed [PosW-1:0]     ofrc_r [3];
  logic                       clr_r;
  logic signed [AccW-1:0]     acc_r  [3];
  logic        [MwW-1:0]      mw_r   [3];
  logic signed [DiffW-1:0]    diff_r [3];
  logic        [SW-1:0]       s_r;
  logic                       zd_r;
  logic signed [ForceW-1:0]   fs_r   [3];
  logic        [SW-1:0]       rem_r;
  logic        [QW-1:0]       nsh_r;
  logic        [QW-1:0]       qt_r;
  logic                       act_r;
  logic                       neg_r;

  logic signed [AccW-1:0]     acc_c  [3];
  logic        [MwW-1:0]      mw_c   [3];
  logic signed [DiffW-1:0]    diff_c [3];
  logic        [SW-1:0]       s_c;
  logic signed [ForceW-1:0]   fs_c   [3];
  logic signed [DiffW-1:0]    dsel;
  logic        [DiffW-1:0]    mag;
  logic        [ProdW-1:0]    prod;
  logic        [NumW-1:0]     num;
  logic        [SW:0]         rem2;
  logic                       ge;
  logic                       rnd;
  logic        [QW:0]         q;
  logic signed [NpW-1:0]      np;

  assign cfg_ch.ready   = 1'b1;
  assign in_ch.ready    = cmd.in_ready;
  assign out_ch.valid   = cmd.out_valid;
  assign stat.in_valid  = in_ch.valid;
  assign stat.out_ready = out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= '{default: '0};
      tgt_r <= '{default: '0};
      im_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_WEIGHT_A: w_r[0]   <= cfg_ch.data[WgtW-1:0];
        CFG_WEIGHT_B: w_r[1]   <= cfg_ch.data[WgtW-1:0];
        CFG_WEIGHT_C: w_r[2]   <= cfg_ch.data[WgtW-1:0];
        CFG_TARGET_X: tgt_r[0] <= cfg_ch.data[PosW-1:0];
        CFG_TARGET_Y: tgt_r[1] <= cfg_ch.data[PosW-1:0];
        CFG_TARGET_Z: tgt_r[2] <= cfg_ch.data[PosW-1:0];
        CFG_INV_MASS: im_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [AccW-1:0]   rsum;
    logic signed [PntW-1:0]   pnt;
    logic signed [ForceW-1:0] base;
    logic signed [ForceW:0]   fsum;
    s_c = '0;
    for (int k = 0; k < 3; k++) begin
      mw_c[k] = MwW'(im_r[ImW*k +: ImW]) * MwW'(w_r[k]);
      s_c     = s_c + SW'(mw_r[k]) * SW'(w_r[k]);
    end
    for (int a = 0; a < 3; a++) begin
      acc_c[a] = '0;
      for (int k = 0; k < 3; k++) begin
        acc_c[a] = acc_c[a] + AccW'($signed({1'b0, w_r[k]}) * pos_r[k][a]);
      end
      rsum      = acc_r[a] + AccW'(8192);
      pnt       = rsum[AccW-1:14];
      diff_c[a] = DiffW'(pnt) - DiffW'(tgt_r[a]);
      base      = clr_r ? '0 : fs_r[a];
      fsum      = (ForceW+1)'(base) + (ForceW+1)'(diff_c[a]);
      if (fsum[ForceW] != fsum[ForceW-1]) begin
        fs_c[a] = fsum[ForceW] ? {1'b1, {(ForceW-1){1'b0}}} : {1'b0, {(ForceW-1){1'b1}}};
      end else begin
        fs_c[a] = fsum[ForceW-1:0];
      end
    end
  end

  always_comb begin
    dsel = diff_r[cmd.a];
    mag  = dsel[DiffW-1] ? DiffW'(-dsel) : DiffW'(dsel);
    prod = ProdW'(mag) * ProdW'(mw_r[cmd.k]);
    num  = {prod, 14'b0};
    rem2 = {rem_r, nsh_r[QW-1]};
    ge   = rem2 >= {1'b0, s_r};
    rnd  = {rem_r, 1'b0} >= {1'b0, s_r};
    q    = {1'b0, qt_r} + (QW+1)'(rnd);
    np   = NpW'(pos_r[cmd.k][cmd.a]);
    if (act_r) begin
      np = neg_r ? np + NpW'(q) : np - NpW'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= '{default: '0};
    end else if (cmd.calc2) begin
      fs_r <= fs_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      clr_r        <= in_ch.clear_force;
      pos_r[0][0]  <= in_ch.a_x;
      pos_r[0][1]  <= in_ch.a_y;
      pos_r[0][2]  <= in_ch.a_z;
      pos_r[1][0]  <= in_ch.b_x;
      pos_r[1][1]  <= in_ch.b_y;
      pos_r[1][2]  <= in_ch.b_z;
      pos_r[2][0]  <= in_ch.c_x;
      pos_r[2][1]  <= in_ch.c_y;
      pos_r[2][2]  <= in_ch.c_z;
    end
    if (cmd.calc1) begin
      acc_r <= acc_c;
      mw_r  <= mw_c;
    end
    if (cmd.calc2) begin
      diff_r <= diff_c;
      s_r    <= s_c;
      zd_r   <= (diff_c[0] == '0) && (diff_c[1] == '0) && (diff_c[2] == '0);
    end
    if (cmd.mul) begin
      rem_r <= SW'(num[NumW-1:QW]);
      nsh_r <= num[QW-1:0];
      qt_r  <= '0;
      act_r <= (s_r != '0) && !zd_r && (mw_r[cmd.k] != '0) && (dsel != '0);
      neg_r <= dsel[DiffW-1];
    end
    if (cmd.div_step) begin
      rem_r <= ge ? SW'(rem2 - {1'b0, s_r}) : SW'(rem2);
      nsh_r <= {nsh_r[QW-2:0], 1'b0};
      qt_r  <= {qt_r[QW-2:0], ge};
    end
    if (cmd.fix) begin
      newp_r[cmd.k][cmd.a] <= sat32(np);
    end
    if (cmd.load_out) begin
      opos_r <= newp_r;
      for (int a = 0; a < 3; a++) begin
        ofrc_r[a] <= sat32(NpW'(fs_r[a]));
      end
    end
  end

  assign out_ch.new_a_x = opos_r[0][0];
  assign out_ch.new_a_y = opos_r[0][1];
  assign out_ch.new_a_z = opos_r[0][2];
  assign out_ch.new_b_x = opos_r[1][0];
  assign out_ch.new_b_y = opos_r[1][1];
  assign out_ch.new_b_z = opos_r[1][2];
  assign out_ch.new_c_x = opos_r[2][0];
  assign out_ch.new_c_y = opos_r[2][1];
  assign out_ch.new_c_z = opos_r[2][2];
  assign out_ch.force_x = ofrc_r[0];
  assign out_ch.force_y = ofrc_r[1];
  assign out_ch.force_z = ofrc_r[2];

endmodule

`default_nettype wire

// ----- src/barycentric_point_pin_constraint_unit.sv -----
// ----------------------------------------------------------------------------
// barycentric_point_pin_constraint_unit
// Projects a triangle point pinned to a target and accumulates the offset.
// ----------------------------------------------------------------------------
// Channels: in_ch carries the three vertex positions and the clear_force flag,
// out_ch returns the nine corrected positions and the three force sums,
// cfg_ch writes weights, target and inverse masses (always ready, write only
// while the unit is idle).
// Sequence: after an item is accepted, the setup steps CALC1 and CALC2 run,
// then for each of the nine vertex-axis pairs a multiply, the radix-2 divider
// steps and a correction, then the load into the output register. A single
// shared multiplier and divider serve all nine pairs.
// Flow: one item at a time; in_ch takes the next item as soon as
// the previous result sits in the output register.
// Stall: a result waits in the output register while out_ch is not ready;
// one more item can be worked and then waits until the register frees up.
// Reset: rst_n clears the configuration registers, the force sums and all
// handshake state; no item is pending afterward.
// ----------------------------------------------------------------------------
`default_nettype none

module barycentric_point_pin_constraint_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bppc_in_if.sink    in_ch,
  bppc_out_if.source out_ch,
  bppc_cfg_if.sink   cfg_ch
);
  import bppc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bppc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  bppc_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule

`default_nettype wire

// ----- tb/tb_barycentric_point_pin_constraint_unit.sv -----
// ----------------------------------------------------------------------------
// tb_barycentric_point_pin_constraint_unit
// Drives vertex triples through the pin constraint unit under a series of
// weight, target and inverse mass settings, predicts each corrected triple
// and force sum in a scoreboard, and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_barycentric_point_pin_constraint_unit;
  import bppc_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;
  localparam longint CycleLimit = 12_000_000;
  localparam int     DrainWait  = 500;

  class pin_scoreboard;
    bit [14:0]   weight[3];
    bit [31:0]   target[3];
    bit [47:0]   inv_mass;
    longint      force_acc[3];
    bit [383:0]  expected_pos[$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < 3; i++) begin
        weight[i] = '0;
        target[i] = '0;
        force_acc[i] = 0;
      end
      inv_mass = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] data);
      case (idx)
        CFG_WEIGHT_A: weight[0] = data[14:0];
        CFG_WEIGHT_B: weight[1] = data[14:0];
        CFG_WEIGHT_C: weight[2] = data[14:0];
        CFG_TARGET_X: target[0] = data[31:0];
        CFG_TARGET_Y: target[1] = data[31:0];
        CFG_TARGET_Z: target[2] = data[31:0];
        CFG_INV_MASS: inv_mass = data;
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function bit [383:0] project(bit clr, bit [287:0] p);
      longint      pos[3][3];
      longint      diff[3];
      longint      im[3];
      longint      acc, s, m, mag, q, np;
      bit          zero_diff;
      bit [127:0]  num, quo, rem;
      bit [383:0]  r;
      longint      cap;
      cap = 64'h3FFF_FFFF_FFFF_FFFF;
      s = 0;
      zero_diff = 1'b1;
      for (int k = 0; k < 3; k++) begin
        im[k] = longint'(inv_mass[16*k +: 16]);
        s += im[k] * longint'(weight[k]) * longint'(weight[k]);
        for (int a = 0; a < 3; a++) begin
          pos[k][a] = longint'($signed(p[(3*k+a)*32 +: 32]));
        end
      end
      if (clr) begin
        for (int a = 0; a < 3; a++) force_acc[a] = 0;
      end
      for (int a = 0; a < 3; a++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += longint'(weight[k]) * pos[k][a];
        diff[a] = ((acc + 8192) >>> 14) - longint'($signed(target[a]));
        if (diff[a] != 0) zero_diff = 1'b0;
        force_acc[a] = clamp(force_acc[a] + diff[a], -64'sd549755813888,
                             64'sd549755813887);
      end
      for (int k = 0; k < 3; k++) begin
        m = (im[k] * longint'(weight[k])) << 14;
        for (int a = 0; a < 3; a++) begin
          np = pos[k][a];
          if (s != 0 && !zero_diff && m != 0 && diff[a] != 0) begin
            mag = diff[a] < 0 ? -diff[a] : diff[a];
            num = 128'(mag) * 128'(m);
            quo = num / 128'(s);
            rem = num % 128'(s);
            if (quo >= 128'(cap) + 128'd1) begin
              q = cap;
            end else begin
              q = longint'(quo[63:0]);
              if (2 * rem >= 128'(s)) q++;
              if (q > cap) q = cap;
            end
            np = diff[a] < 0 ? np + q : np - q;
          end
          r[(3*k+a)*32 +: 32] = 32'(clamp(np, -64'sd2147483648, 64'sd2147483647));
        end
      end
      for (int a = 0; a < 3; a++) begin
        r[(9+a)*32 +: 32] = 32'(clamp(force_acc[a], -64'sd2147483648,
                                      64'sd2147483647));
      end
      return r;
    endfunction

    function void note_input(bit clr, bit [287:0] p);
      expected_pos = {expected_pos, project(clr, p)};
    endfunction

    function void check_result(bit [383:0] got);
      bit [383:0] exp_r;
      if (expected_pos.size() == 0) begin
        $display("%0t: result with no item pending: %h", $time, got);
        errors++;
        return;
      end
      exp_r = expected_pos.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (exp_r[i*32 +: 32] !== got[i*32 +: 32]) begin
          $display("%0t: field %0d expected %h actual %h", $time, i,
                   exp_r[i*32 +: 32], got[i*32 +: 32]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bppc_in_if  in_ch();
  bppc_out_if out_ch();
  bppc_cfg_if cfg_ch();

  pin_scoreboard sb = new();
  longint cycles = 0;
  bit     no_idle;
  int     stall_left = 0;

  barycentric_point_pin_constraint_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 5);
    return $urandom_range(20, 600);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.force_z, out_ch.force_y, out_ch.force_x,
                       out_ch.new_c_z, out_ch.new_c_y, out_ch.new_c_x,
                       out_ch.new_b_z, out_ch.new_b_y, out_ch.new_b_x,
                       out_ch.new_a_z, out_ch.new_a_y, out_ch.new_a_x});
    end
  end

  function automatic bit [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endcase
  endfunction

  function automatic bit [14:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 15'($urandom_range(0, 16384));
    if (r < 85) return 15'd16384;
    if (r < 93) return 15'd0;
    return 15'($urandom);
  endfunction

  function automatic bit [15:0] rand_mass();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0;
    if (r == 1) return 16'hFFFF;
    if (r < 6) return 16'($urandom_range(16, 1024));
    return 16'($urandom);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(bit [14:0] wa, bit [14:0] wb, bit [14:0] wc,
                            bit [31:0] tx, bit [31:0] ty, bit [31:0] tz,
                            bit [47:0] im);
    write_reg(CFG_WEIGHT_A, 48'(wa));
    write_reg(CFG_WEIGHT_B, 48'(wb));
    write_reg(CFG_WEIGHT_C, 48'(wc));
    write_reg(CFG_TARGET_X, 48'(tx));
    write_reg(CFG_TARGET_Y, 48'(ty));
    write_reg(CFG_TARGET_Z, 48'(tz));
    write_reg(CFG_INV_MASS, im);
  endtask

  task automatic send_item(bit clr, bit [287:0] p);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.clear_force <= clr;
    in_ch.a_x <= p[0*32 +: 32];
    in_ch.a_y <= p[1*32 +: 32];
    in_ch.a_z <= p[2*32 +: 32];
    in_ch.b_x <= p[3*32 +: 32];
    in_ch.b_y <= p[4*32 +: 32];
    in_ch.b_z <= p[5*32 +: 32];
    in_ch.c_x <= p[6*32 +: 32];
    in_ch.c_y <= p[7*32 +: 32];
    in_ch.c_z <= p[8*32 +: 32];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(clr, p);
  endtask

  task automatic send_random(int n);
    bit [287:0] p;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 9; j++) p[j*32 +: 32] = rand_coord();
      send_item($urandom_range(0, 7) == 0, p);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_pos.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  initial begin
    sb.reset_state();
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.clear_force = 1'b0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z} = '0;
    {in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    {in_ch.c_x, in_ch.c_y, in_ch.c_z} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: S is zero, positions pass
    send_item(1'b0, {9{32'h7FFF_FFFF}});
    send_item(1'b0, {9{32'h8000_0000}});
    send_item(1'b1, {9{32'h0001_0000}});
    drain();

    // point equals target on first vertex
    set_config(15'd16384, 15'd0, 15'd0, 32'h0, 32'h0, 32'h0, 48'h0100_0100_0100);
    write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
    send_item(1'b1, 288'h0);
    send_item(1'b0, {{6{32'h1234_5678}}, 96'h0});
    send_item(1'b0, {192'h0, 32'h0001_0000, 32'h0, 32'h0});
    send_item(1'b0, {9{32'h7FFF_FFFF}});
    send_item(1'b0, {9{32'h8000_0000}});
    drain();

    // extremes: oversize weights, heaviest inverse masses, saturation
    no_idle = 1'b1;
    set_config(15'h7FFF, 15'h7FFF, 15'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 6; i++) send_item(i == 0, {9{32'h7FFF_FFFF}});
    for (int i = 0; i < 6; i++) send_item(1'b0, {9{32'h8000_0000}});
    send_item(1'b0, {9{32'h0}});
    send_random(120);
    drain();
    no_idle = 1'b0;

    set_config(15'd0, 15'd16384, 15'd0, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 48'h0000_FFFF_0000);
    send_item(1'b1, {9{32'h8000_0000}});
    send_random(150);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      no_idle = (ph == 3);
      set_config(rand_weight(), rand_weight(), rand_weight(), rand_coord(),
                 rand_coord(), rand_coord(), {rand_mass(), rand_mass(), rand_mass()});
      send_random(225);
      drain();
    end

    if (sb.errors == 0 && sb.expected_pos.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/bppc_pkg.sv
src/bppc_ifs.sv
src/bppc_ctrl.sv
src/bppc_dp.sv
src/barycentric_point_pin_constraint_unit.sv
tb/tb_barycentric_point_pin_constraint_unit.sv
